// ===== design/assert_macros.svh =====
// assertion helper macros for the triangle face normal block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== design/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// shared widths and helper types for the face normal pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package tfn_pkg;
    localparam int COORD_W  = 24;
    localparam int EDGE_W   = 25;
    localparam int CROSS_W  = 51;
    localparam int MAG_W    = 50;
    localparam int OUT_W    = 16;
    localparam int RED_W    = 30;
    localparam int TOP_BIT  = 29;
    localparam int SUM_W    = 62;
    localparam int ROOT_W   = 31;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [RED_W-1:0]          red_t;

    // sideband that travels with each item
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic degen;
        logic last;
    } side_t;
endpackage
`default_nettype wire

// ===== design/triangle_face_normal_core.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// unit face normal of one triangle per item, fully pipelined
// ----------------------------------------------------------------------------
// stages in order: cross and scale, square, root, divide, output register
// throughput: one item per cycle while the output is not stalled, set by the
// bit-per-stage root and divide
// the whole pipe advances when the output register is empty or being taken
// reset clears all valid bits, payload registers are not reset
`default_nettype none
module triangle_face_normal_core #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire tfn_pkg::coord_t first_x, first_y, first_z,
    input  wire tfn_pkg::coord_t second_x, second_y, second_z,
    input  wire tfn_pkg::coord_t third_x, third_y, third_z,
    input  wire logic last_triangle,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic signed [tfn_pkg::OUT_W-1:0] normal_x, normal_y, normal_z,
    output logic      degenerate,
    output logic      last_normal
);
    import tfn_pkg::*;

    logic   en;
    logic   c_v, c_last, s_v, n_v;
    cross_t cx, cy, cz;
    red_t   rx, ry, rz;
    side_t  s_side, n_side;
    logic signed [OUT_W-1:0] nx, ny, nz;
    logic   ov_reg;

    // global stall: move only when the output slot frees up
    assign en       = !ov_reg || out_ready;
    assign in_ready = en;

    tfn_cross u_cross (
        .clk, .rst_n, .en, .in_v(in_valid),
        .v0x(first_x), .v0y(first_y), .v0z(first_z),
        .v1x(second_x), .v1y(second_y), .v1z(second_z),
        .v2x(third_x), .v2y(third_y), .v2z(third_z),
        .in_last(last_triangle), .out_v(c_v), .cx, .cy, .cz, .out_last(c_last)
    );

    tfn_scale u_scale (
        .clk, .rst_n, .en, .in_v(c_v), .cx, .cy, .cz, .in_last(c_last),
        .out_v(s_v), .rx, .ry, .rz, .side(s_side)
    );

    tfn_norm #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_norm (
        .clk, .rst_n, .en, .in_v(s_v), .rx, .ry, .rz, .side_in(s_side),
        .out_v(n_v), .nx, .ny, .nz, .side_out(n_side)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= n_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            normal_x    <= nx;
            normal_y    <= ny;
            normal_z    <= nz;
            degenerate  <= n_side.degen;
            last_normal <= n_side.last;
        end
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// ===== design/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// edge differences and cross product, two register stages
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_cross (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_v,
    input  wire tfn_pkg::coord_t v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z,
    input  wire logic           in_last,
    output logic                out_v,
    output tfn_pkg::cross_t     cx, cy, cz,
    output logic                out_last
);
    import tfn_pkg::*;

    edge_t ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic  v1_reg, l1_reg;
    logic signed [2*EDGE_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic  v2_reg, l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= EDGE_W'(v0x) - EDGE_W'(v1x);
            ay_reg <= EDGE_W'(v0y) - EDGE_W'(v1y);
            az_reg <= EDGE_W'(v0z) - EDGE_W'(v1z);
            bx_reg <= EDGE_W'(v2x) - EDGE_W'(v1x);
            by_reg <= EDGE_W'(v2y) - EDGE_W'(v1y);
            bz_reg <= EDGE_W'(v2z) - EDGE_W'(v1z);
            l1_reg <= in_last;
            p0_reg <= ay_reg * bz_reg;
            p1_reg <= az_reg * by_reg;
            p2_reg <= az_reg * bx_reg;
            p3_reg <= ax_reg * bz_reg;
            p4_reg <= ax_reg * by_reg;
            p5_reg <= ay_reg * bx_reg;
            l2_reg <= l1_reg;
        end
    end

    assign out_v    = v2_reg;
    assign out_last = l2_reg;
    assign cx = CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
    assign cy = CROSS_W'(p2_reg) - CROSS_W'(p3_reg);
    assign cz = CROSS_W'(p4_reg) - CROSS_W'(p5_reg);
endmodule
`default_nettype wire

// ===== design/tfn_scale.sv =====
// ----------------------------------------------------------------------------
// tfn_scale
// magnitudes, leading one search and shift to a 30 bit mantissa
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_scale (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_v,
    input  wire tfn_pkg::cross_t cx, cy, cz,
    input  wire logic           in_last,
    output logic                out_v,
    output tfn_pkg::red_t       rx, ry, rz,
    output tfn_pkg::side_t      side
);
    import tfn_pkg::*;

    mag_t  mx_reg, my_reg, mz_reg, mm_reg;
    side_t s1_reg, s2_reg;
    logic  v1_reg, v2_reg;
    red_t  rx_reg, ry_reg, rz_reg;
    mag_t  mx, my, mz, mm;
    logic [5:0] pos;

    always_comb
    begin
        mx = MAG_W'(cx[CROSS_W-1] ? -cx : cx);
        my = MAG_W'(cy[CROSS_W-1] ? -cy : cy);
        mz = MAG_W'(cz[CROSS_W-1] ? -cz : cz);
    end

    // leading one of the largest magnitude
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < MAG_W; i++)
            if (mm_reg[i])
                pos = 6'(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx;
            my_reg <= my;
            mz_reg <= mz;
            mm_reg <= (mx | my | mz);
            s1_reg.neg_x <= cx[CROSS_W-1];
            s1_reg.neg_y <= cy[CROSS_W-1];
            s1_reg.neg_z <= cz[CROSS_W-1];
            s1_reg.degen <= (mx | my | mz) == '0;
            s1_reg.last  <= in_last;
            s2_reg <= s1_reg;
            if (pos < 6'(TOP_BIT))
            begin
                rx_reg <= RED_W'(mx_reg << (6'(TOP_BIT) - pos));
                ry_reg <= RED_W'(my_reg << (6'(TOP_BIT) - pos));
                rz_reg <= RED_W'(mz_reg << (6'(TOP_BIT) - pos));
            end
            else
            begin
                rx_reg <= RED_W'(mx_reg >> (pos - 6'(TOP_BIT)));
                ry_reg <= RED_W'(my_reg >> (pos - 6'(TOP_BIT)));
                rz_reg <= RED_W'(mz_reg >> (pos - 6'(TOP_BIT)));
            end
        end
    end

    assign out_v = v2_reg;
    assign side  = s2_reg;
    assign rx = rx_reg;
    assign ry = ry_reg;
    assign rz = rz_reg;
endmodule
`default_nettype wire

// ===== design/tfn_norm.sv =====
// ----------------------------------------------------------------------------
// tfn_norm
// sum of squares, pipelined square root and three pipelined dividers
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_norm #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_v,
    input  wire tfn_pkg::red_t  rx, ry, rz,
    input  wire tfn_pkg::side_t side_in,
    output logic                out_v,
    output logic signed [tfn_pkg::OUT_W-1:0] nx, ny, nz,
    output tfn_pkg::side_t      side_out
);
    import tfn_pkg::*;

    localparam int NUM_W = RED_W + NORMAL_FRAC_BITS + 1;
    localparam int QW    = NORMAL_FRAC_BITS + 2;
    localparam int SQ    = ROOT_W;
    localparam int DEPTH = 2 + SQ + QW;

    // stage a: squares
    logic [2*RED_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    red_t ax_reg, ay_reg, az_reg;
    side_t sa_reg;
    logic va_reg;

    // root pipeline, one result bit per stage
    logic [SUM_W-1:0] rem_reg [SQ+1];
    logic [SUM_W-1:0] num_reg [SQ+1];
    logic [ROOT_W-1:0] rt_reg [SQ+1];
    red_t qx_r [SQ+1];
    red_t qy_r [SQ+1];
    red_t qz_r [SQ+1];
    side_t ss_reg [SQ+1];
    logic  vs_reg [SQ+1];

    // divide pipeline, one quotient bit per stage
    logic [NUM_W:0] dxr_reg [QW+1];
    logic [NUM_W:0] dyr_reg [QW+1];
    logic [NUM_W:0] dzr_reg [QW+1];
    logic [QW-1:0] qxq_reg [QW+1];
    logic [QW-1:0] qyq_reg [QW+1];
    logic [QW-1:0] qzq_reg [QW+1];
    logic [ROOT_W-1:0] dl_reg [QW+1];
    logic [NUM_W-1:0] nxn_reg [QW+1];
    logic [NUM_W-1:0] nyn_reg [QW+1];
    logic [NUM_W-1:0] nzn_reg [QW+1];
    side_t sd_reg [QW+1];
    logic  vd_reg [QW+1];

    logic [QW-1:0] fx, fy, fz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            for (int i = 0; i <= SQ; i++)
                vs_reg[i] <= 1'b0;
            for (int i = 0; i <= QW; i++)
                vd_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            va_reg    <= in_v;
            vs_reg[0] <= va_reg;
            for (int i = 1; i <= SQ; i++)
                vs_reg[i] <= vs_reg[i-1];
            vd_reg[0] <= vs_reg[SQ];
            for (int i = 1; i <= QW; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= rx * rx;
            sqy_reg <= ry * ry;
            sqz_reg <= rz * rz;
            ax_reg <= rx;
            ay_reg <= ry;
            az_reg <= rz;
            sa_reg <= side_in;

            num_reg[0] <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
            rem_reg[0] <= '0;
            rt_reg[0]  <= '0;
            qx_r[0] <= ax_reg;
            qy_r[0] <= ay_reg;
            qz_r[0] <= az_reg;
            ss_reg[0] <= sa_reg;
            for (int i = 1; i <= SQ; i++)
            begin : root_step
                logic [SUM_W+1:0] trial;
                logic [SUM_W+1:0] rem2;
                rem2  = {rem_reg[i-1], num_reg[i-1][SUM_W-1 -: 2]};
                trial = {rt_reg[i-1], 2'b01};
                if (rem2 >= trial)
                begin
                    rem_reg[i] <= SUM_W'(rem2 - trial);
                    rt_reg[i]  <= {rt_reg[i-1][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= SUM_W'(rem2);
                    rt_reg[i]  <= {rt_reg[i-1][ROOT_W-2:0], 1'b0};
                end
                num_reg[i] <= {num_reg[i-1][SUM_W-3:0], 2'b00};
                qx_r[i] <= qx_r[i-1];
                qy_r[i] <= qy_r[i-1];
                qz_r[i] <= qz_r[i-1];
                ss_reg[i] <= ss_reg[i-1];
            end

            // numerators with rounding half added
            dl_reg[0]  <= rt_reg[SQ];
            nxn_reg[0] <= (NUM_W'(qx_r[SQ]) << NORMAL_FRAC_BITS) + NUM_W'(rt_reg[SQ] >> 1);
            nyn_reg[0] <= (NUM_W'(qy_r[SQ]) << NORMAL_FRAC_BITS) + NUM_W'(rt_reg[SQ] >> 1);
            nzn_reg[0] <= (NUM_W'(qz_r[SQ]) << NORMAL_FRAC_BITS) + NUM_W'(rt_reg[SQ] >> 1);
            dxr_reg[0] <= '0;
            dyr_reg[0] <= '0;
            dzr_reg[0] <= '0;
            qxq_reg[0] <= '0;
            qyq_reg[0] <= '0;
            qzq_reg[0] <= '0;
            sd_reg[0]  <= ss_reg[SQ];
            for (int i = 1; i <= QW; i++)
            begin : div_step
                logic [NUM_W:0] tx, ty, tz, dd;
                dd = (NUM_W+1)'(dl_reg[i-1]) << (QW - i);
                tx = dxr_reg[i-1];
                ty = dyr_reg[i-1];
                tz = dzr_reg[i-1];
                // remainder here holds numerator minus subtracted part
                if (i == 1)
                begin
                    tx = (NUM_W+1)'(nxn_reg[i-1]);
                    ty = (NUM_W+1)'(nyn_reg[i-1]);
                    tz = (NUM_W+1)'(nzn_reg[i-1]);
                end
                qxq_reg[i] <= {qxq_reg[i-1][QW-2:0], tx >= dd};
                qyq_reg[i] <= {qyq_reg[i-1][QW-2:0], ty >= dd};
                qzq_reg[i] <= {qzq_reg[i-1][QW-2:0], tz >= dd};
                dxr_reg[i] <= (tx >= dd) ? tx - dd : tx;
                dyr_reg[i] <= (ty >= dd) ? ty - dd : ty;
                dzr_reg[i] <= (tz >= dd) ? tz - dd : tz;
                dl_reg[i]  <= dl_reg[i-1];
                nxn_reg[i] <= nxn_reg[i-1];
                nyn_reg[i] <= nyn_reg[i-1];
                nzn_reg[i] <= nzn_reg[i-1];
                sd_reg[i]  <= sd_reg[i-1];
            end
        end
    end

    assign fx = qxq_reg[QW];
    assign fy = qyq_reg[QW];
    assign fz = qzq_reg[QW];

    always_comb
    begin
        side_out = sd_reg[QW];
        if (sd_reg[QW].degen)
        begin
            nx = '0;
            ny = '0;
            nz = '0;
        end
        else
        begin
            nx = OUT_W'(sd_reg[QW].neg_x ? -fx : fx);
            ny = OUT_W'(sd_reg[QW].neg_y ? -fy : fy);
            nz = OUT_W'(sd_reg[QW].neg_z ? -fz : fz);
        end
    end

    assign out_v = vd_reg[QW] && (DEPTH > 0);
endmodule
`default_nettype wire

// ===== design/tfn_checker.sv =====
// ----------------------------------------------------------------------------
// tfn_checker
// port level checks for the face normal core
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tfn_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic degenerate,
    input wire logic signed [15:0] normal_x, normal_y, normal_z
);
    logic normal_zero;

    assign normal_zero = (normal_x | normal_y | normal_z) == 16'sd0;

    `ASSERT_IMPL(a_ready_when_free, clk, rst_n, !out_valid, in_ready)
    `ASSERT_IMPL(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready)
    `ASSERT_IMPL(a_degen_zero, clk, rst_n, out_valid && degenerate, normal_zero)
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(normal_x))
endmodule

bind triangle_face_normal_core tfn_checker u_chk (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .degenerate,
    .normal_x, .normal_y, .normal_z
);
`default_nettype wire

// ===== tb/tb_triangle_face_normal_core.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_core
// self-checking bench for the triangle face normal pipeline: a directed
// table of triangles, then random triangles, every result compared with
// a predicted unit normal in issue order
// ----------------------------------------------------------------------------
`default_nettype none
module tb_triangle_face_normal_core;
    import tfn_pkg::*;

    localparam int NFRAC      = 14;
    localparam int PIPE_DEPTH = NFRAC + 41;
    localparam int N_RANDOM   = 600;

    // one triangle as offered on the input side
    typedef struct {
        logic [23:0] fx, fy, fz, sx, sy, sz, tx, ty, tz;
        logic        last;
    } tri_t;

    // one face normal as seen on the output side
    typedef struct {
        logic [15:0] nx, ny, nz;
        logic        degen;
        logic        last;
    } norm_t;

    // directed row: triangle plus optional hand-typed expectation
    typedef struct {
        tri_t  face;
        bit    typed;
        norm_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [23:0] first_x, first_y, first_z;
    logic signed [23:0] second_x, second_y, second_z;
    logic signed [23:0] third_x, third_y, third_z;
    logic last_triangle;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic degenerate;
    logic last_normal;

    norm_t pending_normals[$];
    int    n_fail;
    bit    stim_done;
    // receiver hold-off request, counted in the receiver's own process
    int    hold_cycles;

    triangle_face_normal_core #(.NORMAL_FRAC_BITS(NFRAC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .third_x(third_x), .third_y(third_y), .third_z(third_z),
        .last_triangle(last_triangle),
        .out_valid(out_valid), .out_ready(out_ready),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate), .last_normal(last_normal)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // integer square root, bit by bit
    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // face normal of one triangle: exact cross product, shift the largest
    // magnitude to bit 29, then divide by the rounded-down length
    function automatic norm_t face_normal(input tri_t t);
        norm_t o;
        logic signed [63:0] e1[3], e2[3], cr[3];
        logic [63:0] mg[3];
        logic [63:0] big, sum, len, q;
        int top;
        e1[0] = 64'(signed'(t.fx)) - 64'(signed'(t.sx));
        e1[1] = 64'(signed'(t.fy)) - 64'(signed'(t.sy));
        e1[2] = 64'(signed'(t.fz)) - 64'(signed'(t.sz));
        e2[0] = 64'(signed'(t.tx)) - 64'(signed'(t.sx));
        e2[1] = 64'(signed'(t.ty)) - 64'(signed'(t.sy));
        e2[2] = 64'(signed'(t.tz)) - 64'(signed'(t.sz));
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        big = 0;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (mg[i] > big) big = mg[i];
        end
        o.last = t.last;
        if (big == 0)
        begin
            o.nx = 0; o.ny = 0; o.nz = 0; o.degen = 1'b1;
            return o;
        end
        top = 0;
        while (top < 63 && (big >> (top + 1)) != 0) top++;
        for (int i = 0; i < 3; i++)
            mg[i] = top < 29 ? mg[i] << (29 - top) : mg[i] >> (top - 29);
        sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        len = root_floor(sum);
        q = ((mg[0] << NFRAC) + (len >> 1)) / len;
        o.nx = cr[0] < 0 ? 16'(-q) : 16'(q);
        q = ((mg[1] << NFRAC) + (len >> 1)) / len;
        o.ny = cr[1] < 0 ? 16'(-q) : 16'(q);
        q = ((mg[2] << NFRAC) + (len >> 1)) / len;
        o.nz = cr[2] < 0 ? 16'(-q) : 16'(q);
        o.degen = 1'b0;
        return o;
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        t.fx = rand_coord(); t.fy = rand_coord(); t.fz = rand_coord();
        t.sx = rand_coord(); t.sy = rand_coord(); t.sz = rand_coord();
        t.tx = rand_coord(); t.ty = rand_coord(); t.tz = rand_coord();
        // now and then a collinear or repeated vertex for the degenerate path
        case ($urandom_range(0, 11))
            0: begin t.tx = t.fx; t.ty = t.fy; t.tz = t.fz; end
            1: begin t.sx = t.fx; t.sy = t.fy; t.sz = t.fz; end
            default: ;
        endcase
        t.last = 1'($urandom);
        return t;
    endfunction

    function automatic tri_t mk_tri(input int a0, a1, a2, b0, b1, b2,
                                    input int c0, c1, c2, input bit lst);
        tri_t t;
        t.fx = 24'(a0); t.fy = 24'(a1); t.fz = 24'(a2);
        t.sx = 24'(b0); t.sy = 24'(b1); t.sz = 24'(b2);
        t.tx = 24'(c0); t.ty = 24'(c1); t.tz = 24'(c2);
        t.last = lst;
        return t;
    endfunction

    function automatic norm_t mk_norm(input int x, y, z, input bit dg, lst);
        norm_t n;
        n.nx = 16'(x); n.ny = 16'(y); n.nz = 16'(z);
        n.degen = dg; n.last = lst;
        return n;
    endfunction

    // hand one triangle to the block and record its expected normal;
    // valid stays high after an accept so items can follow back to back
    task automatic send_tri(input tri_t t, input norm_t want);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        first_x <= t.fx; first_y <= t.fy; first_z <= t.fz;
        second_x <= t.sx; second_y <= t.sy; second_z <= t.sz;
        third_x <= t.tx; third_y <= t.ty; third_z <= t.tz;
        last_triangle <= t.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_normals.push_back(want);
        @(negedge clk);
    endtask

    // sender: directed table then random triangles
    initial
    begin
        row_t rows[$];
        row_t r;
        tri_t t;
        localparam int ONE = 1 << NFRAC;
        int MX, MN;
        MX = 8388607;
        MN = -8388608;
        in_valid = 0;
        first_x = 0; first_y = 0; first_z = 0;
        second_x = 0; second_y = 0; second_z = 0;
        third_x = 0; third_y = 0; third_z = 0;
        last_triangle = 0;
        n_fail = 0;
        stim_done = 0;
        hold_cycles = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // all vertices equal: degenerate, zero normal
        r.face = mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0); r.typed = 1;
        r.want = mk_norm(0, 0, 0, 1, 0); rows.push_back(r);
        r.face = mk_tri(MX, MN, MX, MX, MN, MX, MX, MN, MX, 1); r.typed = 1;
        r.want = mk_norm(0, 0, 0, 1, 1); rows.push_back(r);
        // collinear vertices: degenerate
        r.face = mk_tri(1, 2, 3, 0, 0, 0, 2, 4, 6, 0); r.typed = 1;
        r.want = mk_norm(0, 0, 0, 1, 0); rows.push_back(r);
        // axis-aligned triangles give unit axes, both signs
        r.face = mk_tri(4096, 0, 0, 0, 0, 0, 0, 4096, 0, 0); r.typed = 1;
        r.want = mk_norm(0, 0, ONE, 0, 0); rows.push_back(r);
        r.face = mk_tri(0, 4096, 0, 0, 0, 0, 4096, 0, 0, 1); r.typed = 1;
        r.want = mk_norm(0, 0, -ONE, 0, 1); rows.push_back(r);
        r.face = mk_tri(0, 1, 0, 0, 0, 0, 0, 0, 1, 0); r.typed = 1;
        r.want = mk_norm(ONE, 0, 0, 0, 0); rows.push_back(r);
        r.face = mk_tri(0, 0, 1, 0, 0, 0, 1, 0, 0, 0); r.typed = 1;
        r.want = mk_norm(0, ONE, 0, 0, 0); rows.push_back(r);
        // full-range edges, largest cross product
        r.face = mk_tri(MX, MN, 0, MN, MX, 0, MN, MN, 0, 0); r.typed = 0;
        rows.push_back(r);
        r.face = mk_tri(MX, MX, MX, MN, MN, MN, MX, MN, MX, 1); r.typed = 0;
        rows.push_back(r);
        r.face = mk_tri(MN, 0, MX, MX, MN, 0, 0, MX, MN, 0); r.typed = 0;
        rows.push_back(r);
        // tiny cross products, shift left by many bits
        r.face = mk_tri(1, 0, 0, 0, 0, 0, 0, 1, 1, 0); r.typed = 0;
        rows.push_back(r);
        r.face = mk_tri(-1, 0, 0, 0, 0, 0, 0, -1, 1, 1); r.typed = 0;
        rows.push_back(r);
        r.face = mk_tri(3, 5, 7, 1, 1, 1, 2, 9, 4, 0); r.typed = 0;
        rows.push_back(r);

        foreach (rows[i])
        begin
            if (rows[i].typed)
                send_tri(rows[i].face, rows[i].want);
            else
                send_tri(rows[i].face, face_normal(rows[i].face));
        end

        for (int k = 0; k < N_RANDOM; k++)
        begin
            // stall the receiver for a long stretch to fill the pipe
            if (k == 150) hold_cycles = 3 * PIPE_DEPTH;
            // drain completely before carrying on
            if (k == 350)
            begin
                in_valid <= 1'b0;
                while (pending_normals.size() != 0) @(negedge clk);
                @(negedge clk);
            end
            t = rand_tri();
            send_tri(t, face_normal(t));
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // receiver: random ready, long hold-off when asked
    initial
    begin
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 2) == 0) gap = 0;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        norm_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("normal arrived with none expected");
                n_fail++;
            end
            else
            begin
                w = pending_normals.pop_front();
                if (normal_x !== w.nx)
                begin
                    $error("normal_x expected %0d got %0d",
                        $signed(w.nx), normal_x);
                    n_fail++;
                end
                if (normal_y !== w.ny)
                begin
                    $error("normal_y expected %0d got %0d",
                        $signed(w.ny), normal_y);
                    n_fail++;
                end
                if (normal_z !== w.nz)
                begin
                    $error("normal_z expected %0d got %0d",
                        $signed(w.nz), normal_z);
                    n_fail++;
                end
                if (degenerate !== w.degen)
                begin
                    $error("degenerate expected %0d got %0d", w.degen, degenerate);
                    n_fail++;
                end
                if (last_normal !== w.last)
                begin
                    $error("last_normal expected %0d got %0d", w.last, last_normal);
                    n_fail++;
                end
            end
        end
    end

    // end of run: drain, settle, report
    initial
    begin
        @(posedge rst_n);
        wait (stim_done);
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (n_fail == 0 && pending_normals.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // timeout guard
    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
